[rtl/ngh_pkg.sv]
// Shared types and constants for the noise gate with hold and hysteresis.
// Used by ngh_cfg, ngh_ctrl, ngh_dp and noise_gate_hold_hysteresis; no dependencies.
package ngh_pkg;

    // Parameter defaults
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_BITS_DEF  = 16;

    // Register field widths
    localparam int PWR_CFG_W  = 48;
    localparam int COEF_CFG_W = 16;
    localparam int HOLD_W     = 16;
    localparam int CH_W       = 2;

    // APB port
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_W   = APB_ADDR_W - REG_IDX_LSB;

    // Gain format: unsigned Q1.16
    localparam int GAIN_W    = 17;
    localparam int GAIN_FRAC = 16;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(65536);
    // gain*100 >= 99*unity  <=>  gain >= ceil(0.99 * unity)
    localparam logic [GAIN_W-1:0] GAIN_OPEN_MIN  = GAIN_W'((99 * 65536 + 99) / 100);
    // gain*100 <= unity     <=>  gain <= floor(0.01 * unity)
    localparam logic [GAIN_W-1:0] GAIN_CLOSE_MAX = GAIN_W'(65536 / 100);
    localparam int ROUND_HALF = 32768;

    localparam logic [HOLD_W-1:0]     HOLD_MAX   = {HOLD_W{1'b1}};
    localparam logic [HOLD_W-1:0]     HOLD_RESET = HOLD_W'(480);
    localparam logic [CH_W-1:0]       CH_MONO    = CH_W'(1);
    localparam logic [CH_W-1:0]       CH_RESET   = CH_W'(2);
    localparam logic [COEF_CFG_W-1:0] COEF_RESET = '0;
    localparam logic [PWR_CFG_W-1:0]  PWR_RESET  = '0;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_OPEN_POWER      = 3'd0,
        REG_CLOSE_POWER     = 3'd1,
        REG_ATTACK_COEFF    = 3'd2,
        REG_RELEASE_COEFF   = 3'd3,
        REG_HOLD_SAMPLES    = 3'd4,
        REG_ACTIVE_CHANNELS = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_CLOSED  = 3'd0,
        PH_OPENING = 3'd1,
        PH_OPEN    = 3'd2,
        PH_HOLDING = 3'd3,
        PH_CLOSING = 3'd4
    } gate_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_LEVEL,
        ST_GAIN,
        ST_SCALE
    } ctrl_state_t;

    typedef struct packed {
        logic [PWR_CFG_W-1:0]  open_power;
        logic [PWR_CFG_W-1:0]  close_power;
        logic [COEF_CFG_W-1:0] attack_coeff;
        logic [COEF_CFG_W-1:0] release_coeff;
        logic [HOLD_W-1:0]     hold_samples;
        logic [CH_W-1:0]       active_channels;
    } ngh_cfg_t;

    typedef struct packed {
        logic load_in;   // capture the request's samples
        logic sq_en;     // register both squares
        logic lvl_en;    // register threshold flags
        logic gain_en;   // advance phase, hold count and gain
        logic out_load;  // register scaled result
    } ngh_cmd_t;

endpackage

[rtl/noise_gate_hold_hysteresis.sv]
// Top level of the stereo noise gate with hold and hysteresis.
// Depends on ngh_pkg, ngh_cfg, ngh_ctrl and ngh_dp.

// A frame of two signed samples is taken on the s_ channel and one gated frame is
// returned on the m_ channel, together with the gain applied (unsigned Q1.16,
// 65536 = unity) and the gate phase (closed, opening, open, holding, closing).
// The level is the mean square of the active channels (left only in mono mode,
// where out_right is forced to zero) and is compared against two linear power
// thresholds programmed by the host: above open_power the gate opens, at or
// below close_power an open gate starts to close after hold_samples frames of
// hold, while an opening gate closes at once. Gain ramps with one-pole
// attack/release coefficients in Q0.16. Sequencing: each frame goes through
// four sequencer steps (square, level compare, gain update, scale), and the
// sequencer works on one frame at a time. The next request is taken in the
// cycle the previous result enters the output register, so a stalled consumer
// only holds off the input once a second frame has completed. Registers sit
// on an APB port at byte address 8*index, 64-bit data; write them only while
// no frame is in flight. pready is tied high.
module noise_gate_hold_hysteresis #(
    parameter int SAMPLE_BITS = ngh_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = ngh_pkg::COEFF_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ngh_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ngh_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ngh_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // input frames
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_right,
    // gated frames
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_out_left,
    output logic signed [SAMPLE_BITS-1:0]      m_out_right,
    output logic [ngh_pkg::GAIN_W-1:0]         m_gain_now,
    output logic [2:0]                         m_gate_phase
);

    ngh_pkg::ngh_cfg_t cfg;
    ngh_pkg::ngh_cmd_t cmd;

    // zero-wait APB
    assign pready = 1'b1;

    ngh_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sequencer: owns the handshakes and the output-valid flag
    ngh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath: gate state, gain and the output register
    ngh_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg            (cfg),
        .s_sample_left  (s_sample_left),
        .s_sample_right (s_sample_right),
        .out_left       (m_out_left),
        .out_right      (m_out_right),
        .gain_now       (m_gain_now),
        .gate_phase     (m_gate_phase)
    );

    // An accepted request keeps the input closed while its frame is worked on.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again during frame processing");

    // Loading the output register always raises valid on the next cycle.
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result loaded but not presented");

    // Loading the output never overwrites a result that was not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !cmd.out_load)
        else $error("pending result overwritten");

    // Gain never exceeds unity; open and holding phases run at unity.
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gain_now <= ngh_pkg::GAIN_UNITY) &&
                    ((m_gate_phase != ngh_pkg::PH_OPEN &&
                      m_gate_phase != ngh_pkg::PH_HOLDING) ||
                     m_gain_now == ngh_pkg::GAIN_UNITY))
        else $error("gate gain out of range for its phase");

endmodule

[rtl/ngh_cfg.sv]
// APB register file for the noise gate: thresholds, coefficients, hold, channels.
// Depends on ngh_pkg.
module ngh_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ngh_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [ngh_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ngh_pkg::APB_DATA_W-1:0]       prdata,
    output ngh_pkg::ngh_cfg_t                    cfg
);

    ngh_pkg::ngh_cfg_t  cfg_reg;
    ngh_pkg::reg_index_t idx;
    logic               wr_en;

    assign idx   = ngh_pkg::reg_index_t'(paddr[ngh_pkg::APB_ADDR_W-1:ngh_pkg::REG_IDX_LSB]);
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_power      <= ngh_pkg::PWR_RESET;
            cfg_reg.close_power     <= ngh_pkg::PWR_RESET;
            cfg_reg.attack_coeff    <= ngh_pkg::COEF_RESET;
            cfg_reg.release_coeff   <= ngh_pkg::COEF_RESET;
            cfg_reg.hold_samples    <= ngh_pkg::HOLD_RESET;
            cfg_reg.active_channels <= ngh_pkg::CH_RESET;
        end else if (wr_en) begin
            case (idx)
                ngh_pkg::REG_OPEN_POWER:
                    cfg_reg.open_power <= pwdata[ngh_pkg::PWR_CFG_W-1:0];
                ngh_pkg::REG_CLOSE_POWER:
                    cfg_reg.close_power <= pwdata[ngh_pkg::PWR_CFG_W-1:0];
                ngh_pkg::REG_ATTACK_COEFF:
                    cfg_reg.attack_coeff <= pwdata[ngh_pkg::COEF_CFG_W-1:0];
                ngh_pkg::REG_RELEASE_COEFF:
                    cfg_reg.release_coeff <= pwdata[ngh_pkg::COEF_CFG_W-1:0];
                ngh_pkg::REG_HOLD_SAMPLES:
                    cfg_reg.hold_samples <= pwdata[ngh_pkg::HOLD_W-1:0];
                ngh_pkg::REG_ACTIVE_CHANNELS:
                    cfg_reg.active_channels <= pwdata[ngh_pkg::CH_W-1:0];
                default: ;  // unmapped addresses ignored
            endcase
        end
    end

    always_comb begin
        case (idx)
            ngh_pkg::REG_OPEN_POWER:
                prdata = ngh_pkg::APB_DATA_W'(cfg_reg.open_power);
            ngh_pkg::REG_CLOSE_POWER:
                prdata = ngh_pkg::APB_DATA_W'(cfg_reg.close_power);
            ngh_pkg::REG_ATTACK_COEFF:
                prdata = ngh_pkg::APB_DATA_W'(cfg_reg.attack_coeff);
            ngh_pkg::REG_RELEASE_COEFF:
                prdata = ngh_pkg::APB_DATA_W'(cfg_reg.release_coeff);
            ngh_pkg::REG_HOLD_SAMPLES:
                prdata = ngh_pkg::APB_DATA_W'(cfg_reg.hold_samples);
            ngh_pkg::REG_ACTIVE_CHANNELS:
                prdata = ngh_pkg::APB_DATA_W'(cfg_reg.active_channels);
            default:
                prdata = '0;
        endcase
    end

endmodule

[rtl/ngh_ctrl.sv]
// Sequencer for the noise gate: steps one frame through square, level, gain, scale.
// Depends on ngh_pkg; drives the command struct into ngh_dp.
module ngh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ngh_pkg::ngh_cmd_t cmd
);

    ngh_pkg::ctrl_state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    assign out_free = ~m_valid_reg | m_ready;
    assign m_valid  = m_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ngh_pkg::ST_IDLE:
                if (s_valid) state_next = ngh_pkg::ST_SQUARE;
            ngh_pkg::ST_SQUARE: state_next = ngh_pkg::ST_LEVEL;
            ngh_pkg::ST_LEVEL:  state_next = ngh_pkg::ST_GAIN;
            ngh_pkg::ST_GAIN:   state_next = ngh_pkg::ST_SCALE;
            ngh_pkg::ST_SCALE: begin
                if (out_free) begin
                    state_next = s_valid ? ngh_pkg::ST_SQUARE : ngh_pkg::ST_IDLE;
                end
            end
            default: state_next = ngh_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ngh_pkg::ST_IDLE:   s_ready = 1'b1;
            ngh_pkg::ST_SQUARE: cmd.sq_en = 1'b1;
            ngh_pkg::ST_LEVEL:  cmd.lvl_en = 1'b1;
            ngh_pkg::ST_GAIN:   cmd.gain_en = 1'b1;
            ngh_pkg::ST_SCALE: begin
                s_ready      = out_free;
                cmd.out_load = out_free;
            end
            default: ;
        endcase
        cmd.load_in  = s_valid & s_ready;
        m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ngh_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/ngh_dp.sv]
// Datapath for the noise gate: squares, level compare, gate phase, gain smoothing,
// output scaling. Depends on ngh_pkg; sequenced by ngh_ctrl through ngh_cmd_t.
module ngh_dp #(
    parameter int SAMPLE_BITS = ngh_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = ngh_pkg::COEFF_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ngh_pkg::ngh_cmd_t                 cmd,
    input  ngh_pkg::ngh_cfg_t                 cfg,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample_left,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample_right,
    output logic signed [SAMPLE_BITS-1:0]     out_left,
    output logic signed [SAMPLE_BITS-1:0]     out_right,
    output logic [ngh_pkg::GAIN_W-1:0]        gain_now,
    output logic [2:0]                        gate_phase
);

    localparam int SW    = SAMPLE_BITS;
    localparam int SQ_W  = 2 * SW;
    localparam int PWR_W = (SQ_W > ngh_pkg::PWR_CFG_W) ? SQ_W : ngh_pkg::PWR_CFG_W;
    // coefficient register holds 16 bits; narrower formats drop the top bits
    localparam int CW    = (COEFF_BITS < ngh_pkg::COEF_CFG_W) ? COEFF_BITS
                                                              : ngh_pkg::COEF_CFG_W;
    localparam int GW    = ngh_pkg::GAIN_W;
    localparam int GP_W  = GW + CW;
    localparam int SC_W  = SW + GW + 1;

    // frame and intermediate registers
    logic signed [SW-1:0]   left_reg, right_reg;
    logic [SQ_W-1:0]        sq_left_reg, sq_right_reg;
    logic                   above_open_reg, below_close_reg;
    ngh_pkg::gate_phase_t   phase_reg, phase_next;
    logic [ngh_pkg::HOLD_W-1:0] hold_count_reg, hold_count_next;
    logic [GW-1:0]          gain_reg, gain_next;
    logic signed [SW-1:0]   out_left_reg, out_right_reg;
    logic [GW-1:0]          out_gain_reg;
    ngh_pkg::gate_phase_t   out_phase_reg;

    logic                   mono;
    logic [SW-1:0]          mag_left, mag_right;
    logic [SQ_W:0]          sq_sum;
    logic [SQ_W-1:0]        level;
    logic [PWR_W-1:0]       level_ext;

    logic [ngh_pkg::HOLD_W-1:0] hold_inc;
    logic                   gain_at_open, gain_at_closed;
    logic                   opening;
    logic [GW-1:0]          deficit, mul_a;
    logic [CW-1:0]          mul_c;
    logic [GP_W-1:0]        mul_p, mul_shift;
    logic [GW-1:0]          mul_q;

    logic signed [SC_W-1:0] prod_left, prod_right;
    logic signed [SC_W-1:0] rnd_left, rnd_right;
    logic signed [SC_W-1:0] sh_left, sh_right;

    assign mono = (cfg.active_channels == ngh_pkg::CH_MONO);

    // magnitudes; the most negative code maps to 2^(SW-1), still fits SW bits
    assign mag_left  = left_reg[SW-1]  ? (~left_reg + 1'b1)  : left_reg;
    assign mag_right = right_reg[SW-1] ? (~right_reg + 1'b1) : right_reg;

    assign sq_sum    = {1'b0, sq_left_reg} + {1'b0, sq_right_reg};
    assign level     = mono ? sq_left_reg : sq_sum[SQ_W:1];
    assign level_ext = PWR_W'(level);

    // gate phase and hold counter
    assign hold_inc       = (hold_count_reg != ngh_pkg::HOLD_MAX)
                            ? hold_count_reg + 1'b1 : hold_count_reg;
    assign gain_at_open   = (gain_reg >= ngh_pkg::GAIN_OPEN_MIN);
    assign gain_at_closed = (gain_reg <= ngh_pkg::GAIN_CLOSE_MAX);

    always_comb begin
        phase_next      = phase_reg;
        hold_count_next = hold_count_reg;
        unique case (phase_reg)
            ngh_pkg::PH_OPENING: begin
                if (below_close_reg) begin
                    phase_next = ngh_pkg::PH_CLOSING;
                end else if (gain_at_open) begin
                    phase_next      = ngh_pkg::PH_OPEN;
                    hold_count_next = '0;
                end
            end
            ngh_pkg::PH_OPEN: begin
                if (below_close_reg) begin
                    phase_next      = ngh_pkg::PH_HOLDING;
                    hold_count_next = '0;
                end
            end
            ngh_pkg::PH_HOLDING: begin
                hold_count_next = hold_inc;
                if (above_open_reg) begin
                    phase_next = ngh_pkg::PH_OPEN;
                end else if (hold_inc >= cfg.hold_samples) begin
                    phase_next = ngh_pkg::PH_CLOSING;
                end
            end
            ngh_pkg::PH_CLOSING: begin
                if (above_open_reg) begin
                    phase_next = ngh_pkg::PH_OPENING;
                end else if (gain_at_closed) begin
                    phase_next = ngh_pkg::PH_CLOSED;
                end
            end
            default: begin
                // closed, and any stray code
                phase_next = above_open_reg ? ngh_pkg::PH_OPENING : ngh_pkg::PH_CLOSED;
            end
        endcase
    end

    // one-pole smoothing; one shared multiplier for attack and release
    assign opening   = (phase_next == ngh_pkg::PH_OPENING);
    assign deficit   = ngh_pkg::GAIN_UNITY - gain_reg;
    assign mul_a     = opening ? deficit : gain_reg;
    assign mul_c     = opening ? cfg.attack_coeff[CW-1:0] : cfg.release_coeff[CW-1:0];
    assign mul_p     = GP_W'(mul_a) * GP_W'(mul_c);
    assign mul_shift = mul_p >> COEFF_BITS;
    assign mul_q     = mul_shift[GW-1:0];

    always_comb begin
        unique case (phase_next)
            ngh_pkg::PH_OPENING: gain_next = ngh_pkg::GAIN_UNITY - mul_q;
            ngh_pkg::PH_OPEN,
            ngh_pkg::PH_HOLDING: gain_next = ngh_pkg::GAIN_UNITY;
            ngh_pkg::PH_CLOSING: gain_next = mul_q;
            default:             gain_next = gain_reg;  // closed holds its gain
        endcase
    end

    // output scaling, round half up via floor shift
    assign prod_left  = SC_W'(left_reg)  * SC_W'($signed({1'b0, gain_reg}));
    assign prod_right = SC_W'(right_reg) * SC_W'($signed({1'b0, gain_reg}));
    assign rnd_left   = prod_left  + SC_W'(ngh_pkg::ROUND_HALF);
    assign rnd_right  = prod_right + SC_W'(ngh_pkg::ROUND_HALF);
    assign sh_left    = rnd_left  >>> ngh_pkg::GAIN_FRAC;
    assign sh_right   = rnd_right >>> ngh_pkg::GAIN_FRAC;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= ngh_pkg::PH_CLOSED;
            hold_count_reg <= '0;
            gain_reg       <= '0;
        end else if (cmd.gain_en) begin
            phase_reg      <= phase_next;
            hold_count_reg <= hold_count_next;
            gain_reg       <= gain_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            left_reg  <= s_sample_left;
            right_reg <= s_sample_right;
        end
        if (cmd.sq_en) begin
            sq_left_reg  <= SQ_W'(mag_left)  * SQ_W'(mag_left);
            sq_right_reg <= SQ_W'(mag_right) * SQ_W'(mag_right);
        end
        if (cmd.lvl_en) begin
            above_open_reg  <= (level_ext >  PWR_W'(cfg.open_power));
            below_close_reg <= (level_ext <= PWR_W'(cfg.close_power));
        end
        if (cmd.out_load) begin
            out_left_reg  <= sh_left[SW-1:0];
            out_right_reg <= mono ? '0 : sh_right[SW-1:0];
            out_gain_reg  <= gain_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;
    assign gain_now   = out_gain_reg;
    assign gate_phase = out_phase_reg;

endmodule
